// ===== hdl/dis_pkg.sv =====
`default_nettype none

package dis_pkg;

	localparam int PROG_LEN = 45;
	localparam int PC_W = $clog2(PROG_LEN);

	localparam logic [PC_W-1:0] PC_SEQ = PC_W'(0);
	localparam logic [PC_W-1:0] PC_SLEEP = PC_W'(37);
	localparam logic [PC_W-1:0] PC_EMPTY = PC_W'(38);
	localparam logic [PC_W-1:0] PC_WIN = PC_W'(39);

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_WINDOW = 2'd2;

	localparam logic [1:0] REG_ORIENT = 2'd0;
	localparam logic [1:0] REG_RESET_WAIT = 2'd1;
	localparam logic [1:0] REG_SLEEP_WAIT = 2'd2;

	localparam logic [7:0] CMD_CASET = 8'h2A;
	localparam logic [7:0] CMD_RASET = 8'h2B;
	localparam logic [7:0] CMD_RAMWR = 8'h2C;
	localparam logic [7:0] CMD_SLPOUT = 8'h11;

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_CONST,
		SRC_MADCTL,
		SRC_COORD
	} src_t;

	typedef struct packed {
		src_t src;
		logic is_cmd;
		logic [7:0] val;
	} slot_t;

	typedef struct packed {
		slot_t s0;
		slot_t s1;
		logic last;
	} ctl_word_t;

	function automatic slot_t sc(input logic [7:0] b);
		return '{src: SRC_CONST, is_cmd: 1'b1, val: b};
	endfunction

	function automatic slot_t sd(input logic [7:0] b);
		return '{src: SRC_CONST, is_cmd: 1'b0, val: b};
	endfunction

	function automatic slot_t sn();
		return '{src: SRC_NONE, is_cmd: 1'b0, val: 8'h00};
	endfunction

	function automatic slot_t sm();
		return '{src: SRC_MADCTL, is_cmd: 1'b0, val: 8'h00};
	endfunction

	function automatic slot_t sx();
		return '{src: SRC_COORD, is_cmd: 1'b0, val: 8'h00};
	endfunction

	function automatic logic [7:0] madctl_byte(input logic [1:0] orient);
		logic [7:0] b;
		case (orient)
			2'd0: b = 8'h00;
			2'd1: b = 8'hC0;
			2'd2: b = 8'h70;
			default: b = 8'hA0;
		endcase
		return b;
	endfunction

	// program: one word per result, last marks the end of a routine
	function automatic ctl_word_t prog_word(input logic [PC_W-1:0] pc);
		ctl_word_t w;
		w.last = 1'b0;
		case (pc)
			PC_W'(0): {w.s0, w.s1} = {sc(8'hB1), sd(8'h05)};
			PC_W'(1): {w.s0, w.s1} = {sd(8'h3C), sd(8'h3C)};
			PC_W'(2): {w.s0, w.s1} = {sc(8'hB2), sd(8'h05)};
			PC_W'(3): {w.s0, w.s1} = {sd(8'h3C), sd(8'h3C)};
			PC_W'(4): {w.s0, w.s1} = {sc(8'hB3), sd(8'h05)};
			PC_W'(5): {w.s0, w.s1} = {sd(8'h3C), sd(8'h3C)};
			PC_W'(6): {w.s0, w.s1} = {sd(8'h05), sd(8'h3C)};
			PC_W'(7): {w.s0, w.s1} = {sd(8'h3C), sc(8'hB4)};
			PC_W'(8): {w.s0, w.s1} = {sd(8'h03), sc(8'hC0)};
			PC_W'(9): {w.s0, w.s1} = {sd(8'h28), sd(8'h08)};
			PC_W'(10): {w.s0, w.s1} = {sd(8'h04), sc(8'hC1)};
			PC_W'(11): {w.s0, w.s1} = {sd(8'hC0), sc(8'hC2)};
			PC_W'(12): {w.s0, w.s1} = {sd(8'h0D), sd(8'h00)};
			PC_W'(13): {w.s0, w.s1} = {sc(8'hC3), sd(8'h8D)};
			PC_W'(14): {w.s0, w.s1} = {sd(8'h2A), sc(8'hC4)};
			PC_W'(15): {w.s0, w.s1} = {sd(8'h8D), sd(8'hEE)};
			PC_W'(16): {w.s0, w.s1} = {sc(8'hC5), sd(8'h1A)};
			PC_W'(17): {w.s0, w.s1} = {sc(8'h36), sm()};
			PC_W'(18): {w.s0, w.s1} = {sc(8'hE0), sd(8'h04)};
			PC_W'(19): {w.s0, w.s1} = {sd(8'h22), sd(8'h07)};
			PC_W'(20): {w.s0, w.s1} = {sd(8'h0A), sd(8'h2E)};
			PC_W'(21): {w.s0, w.s1} = {sd(8'h30), sd(8'h25)};
			PC_W'(22): {w.s0, w.s1} = {sd(8'h2A), sd(8'h28)};
			PC_W'(23): {w.s0, w.s1} = {sd(8'h26), sd(8'h2E)};
			PC_W'(24): {w.s0, w.s1} = {sd(8'h3A), sd(8'h00)};
			PC_W'(25): {w.s0, w.s1} = {sd(8'h01), sd(8'h03)};
			PC_W'(26): {w.s0, w.s1} = {sd(8'h13), sc(8'hE1)};
			PC_W'(27): {w.s0, w.s1} = {sd(8'h04), sd(8'h16)};
			PC_W'(28): {w.s0, w.s1} = {sd(8'h06), sd(8'h0D)};
			PC_W'(29): {w.s0, w.s1} = {sd(8'h2D), sd(8'h26)};
			PC_W'(30): {w.s0, w.s1} = {sd(8'h23), sd(8'h27)};
			PC_W'(31): {w.s0, w.s1} = {sd(8'h27), sd(8'h25)};
			PC_W'(32): {w.s0, w.s1} = {sd(8'h2D), sd(8'h3B)};
			PC_W'(33): {w.s0, w.s1} = {sd(8'h00), sd(8'h01)};
			PC_W'(34): {w.s0, w.s1} = {sd(8'h04), sd(8'h13)};
			PC_W'(35): {w.s0, w.s1} = {sc(8'h3A), sd(8'h05)};
			PC_W'(36): begin
				{w.s0, w.s1} = {sc(8'h29), sn()};
				w.last = 1'b1;
			end
			PC_W'(37): begin
				{w.s0, w.s1} = {sc(CMD_SLPOUT), sn()};
				w.last = 1'b1;
			end
			PC_W'(39): {w.s0, w.s1} = {sc(CMD_CASET), sx()};
			PC_W'(40): {w.s0, w.s1} = {sx(), sx()};
			PC_W'(41): {w.s0, w.s1} = {sx(), sc(CMD_RASET)};
			PC_W'(42): {w.s0, w.s1} = {sx(), sx()};
			PC_W'(43): {w.s0, w.s1} = {sx(), sx()};
			PC_W'(44): begin
				{w.s0, w.s1} = {sc(CMD_RAMWR), sn()};
				w.last = 1'b1;
			end
			default: begin
				{w.s0, w.s1} = {sn(), sn()};
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/display_init_sequencer.sv =====
`default_nettype none

// Power-up and window sequencer for a small TFT panel. Each accepted item runs one short
// routine from a control-word table, one word per result: one result for a tick or
// restart that sends no bytes or the sleep-out command, six for a window and 37 for the
// register sequence. out_stall holds a result in the output register, and in_stall stays
// high while a routine runs. A new item is taken while the final result of the previous
// one still waits in the output register. Waits are counted in ticks, not clock cycles.
module display_init_sequencer
	import dis_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] operation,
	input wire logic [15:0] x_start,
	input wire logic [15:0] y_start,
	input wire logic [15:0] x_end,
	input wire logic [15:0] y_end,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] first_byte,
	output logic first_is_command,
	output logic first_valid,
	output logic [7:0] second_byte,
	output logic second_is_command,
	output logic second_valid,
	output logic reset_level,
	output logic backlight_on,
	output logic init_done,
	output logic last
);

	typedef enum logic [3:0] {
		PH_START,
		PH_RESET_LOW,
		PH_WAIT1,
		PH_RESET_HIGH,
		PH_WAIT2,
		PH_BLK_ON,
		PH_WAIT3,
		PH_SLEEP_OUT,
		PH_WAIT4,
		PH_SEQUENCE,
		PH_DONE
	} phase_t;

	logic [1:0] orient_q;
	logic [7:0] reset_wait_q;
	logic [7:0] sleep_wait_q;

	phase_t phase_q, phase_d;
	logic [7:0] wait_q, wait_d;
	logic rst_pin_q, rst_pin_d;
	logic blk_q, blk_d;
	logic busy_q;
	logic [PC_W-1:0] pc_q, pc_start;
	logic [63:0] coord_q;

	logic out_valid_q;
	logic [7:0] b0_q, b1_q;
	logic c0_q, c1_q, v0_q, v1_q;
	logic rst_lvl_q, blk_lvl_q, done_q, last_q;

	logic in_xfer;
	logic load;
	ctl_word_t word;
	logic [15:0] x_off, y_off;
	logic [7:0] b0, b1;
	logic c0, c1, v0, v1;
	logic sh0, sh1;

	assign in_stall = busy_q;
	assign in_xfer = in_valid && !in_stall;
	assign load = busy_q && (!out_valid_q || !out_stall);
	assign word = prog_word(pc_q);

	assign x_off = orient_q[1] ? 16'd1 : 16'd2;
	assign y_off = orient_q[1] ? 16'd2 : 16'd1;

	// tick state update and routine dispatch
	always_comb begin
		phase_d = phase_q;
		wait_d = wait_q;
		rst_pin_d = rst_pin_q;
		blk_d = blk_q;
		pc_start = PC_EMPTY;
		case (operation)
			OP_TICK: begin
				if (phase_q == PH_DONE) begin
					phase_d = PH_DONE;
				end else if (wait_q != 8'd0) begin
					wait_d = wait_q - 8'd1;
				end else begin
					case (phase_q)
						PH_START: phase_d = PH_RESET_LOW;
						PH_RESET_LOW: begin
							rst_pin_d = 1'b0;
							wait_d = reset_wait_q;
							phase_d = PH_WAIT1;
						end
						PH_WAIT1: phase_d = PH_RESET_HIGH;
						PH_RESET_HIGH: begin
							rst_pin_d = 1'b1;
							wait_d = reset_wait_q;
							phase_d = PH_WAIT2;
						end
						PH_WAIT2: phase_d = PH_BLK_ON;
						PH_BLK_ON: begin
							blk_d = 1'b1;
							wait_d = reset_wait_q;
							phase_d = PH_WAIT3;
						end
						PH_WAIT3: phase_d = PH_SLEEP_OUT;
						PH_SLEEP_OUT: begin
							pc_start = PC_SLEEP;
							wait_d = sleep_wait_q;
							phase_d = PH_WAIT4;
						end
						PH_WAIT4: phase_d = PH_SEQUENCE;
						PH_SEQUENCE: begin
							pc_start = PC_SEQ;
							phase_d = PH_DONE;
						end
						default: phase_d = PH_DONE;
					endcase
				end
			end
			OP_RESTART: phase_d = PH_START;
			OP_WINDOW: pc_start = PC_WIN;
			default: pc_start = PC_EMPTY;
		endcase
	end

	// byte slot datapath
	always_comb begin
		b0 = 8'h00;
		c0 = 1'b0;
		v0 = 1'b1;
		sh0 = 1'b0;
		case (word.s0.src)
			SRC_NONE: v0 = 1'b0;
			SRC_CONST: begin
				b0 = word.s0.val;
				c0 = word.s0.is_cmd;
			end
			SRC_MADCTL: b0 = madctl_byte(orient_q);
			SRC_COORD: begin
				b0 = coord_q[63:56];
				sh0 = 1'b1;
			end
			default: v0 = 1'b0;
		endcase
		b1 = 8'h00;
		c1 = 1'b0;
		v1 = 1'b1;
		sh1 = 1'b0;
		case (word.s1.src)
			SRC_NONE: v1 = 1'b0;
			SRC_CONST: begin
				b1 = word.s1.val;
				c1 = word.s1.is_cmd;
			end
			SRC_MADCTL: b1 = madctl_byte(orient_q);
			SRC_COORD: begin
				b1 = sh0 ? coord_q[55:48] : coord_q[63:56];
				sh1 = 1'b1;
			end
			default: v1 = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= 2'd0;
			reset_wait_q <= 8'd20;
			sleep_wait_q <= 8'd24;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ORIENT: orient_q <= cfg_data[1:0];
				REG_RESET_WAIT: reset_wait_q <= cfg_data;
				REG_SLEEP_WAIT: sleep_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			wait_q <= 8'd0;
			rst_pin_q <= 1'b1;
			blk_q <= 1'b0;
			busy_q <= 1'b0;
			pc_q <= PC_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				phase_q <= phase_d;
				wait_q <= wait_d;
				rst_pin_q <= rst_pin_d;
				blk_q <= blk_d;
				pc_q <= pc_start;
				busy_q <= 1'b1;
			end else if (load) begin
				if (word.last) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			coord_q <= {x_start + x_off, x_end + x_off, y_start + y_off, y_end + y_off};
		end else if (load) begin
			if (sh0 && sh1) begin
				coord_q <= {coord_q[47:0], 16'h0000};
			end else if (sh0 || sh1) begin
				coord_q <= {coord_q[55:0], 8'h00};
			end
		end
		if (load) begin
			b0_q <= b0;
			c0_q <= c0;
			v0_q <= v0;
			b1_q <= b1;
			c1_q <= c1;
			v1_q <= v1;
			rst_lvl_q <= rst_pin_q;
			blk_lvl_q <= blk_q;
			done_q <= (phase_q == PH_DONE);
			last_q <= word.last;
		end
	end

	assign out_valid = out_valid_q;
	assign first_byte = b0_q;
	assign first_is_command = c0_q;
	assign first_valid = v0_q;
	assign second_byte = b1_q;
	assign second_is_command = c1_q;
	assign second_valid = v1_q;
	assign reset_level = rst_lvl_q;
	assign backlight_on = blk_lvl_q;
	assign init_done = done_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < PC_W'(PROG_LEN)))
		else $error("step counter past end of program");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(phase_q == PH_DONE) |-> $past(in_xfer && operation == OP_RESTART))
		else $error("init done dropped without restart");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !v0_q |-> !v1_q)
		else $error("second byte present without first");

	a_no_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && out_valid_q && !out_stall |=> !out_valid_q || busy_q || $past(in_xfer))
		else $error("result produced while idle");
`endif

endmodule

`default_nettype wire
